// ----- hdl/lsp_pkg.sv -----
// ----------------------------------------------------------------------------
// LED strip pattern engine package
// Shared types, command codes and sizing constants.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int MAX_PIXELS_DEF = 1024;
  localparam int IDX_W          = 12;  // span indices and lengths
  localparam int NUM_W          = 21;  // signed running numerator i*(c2-c1)
  localparam int DVD_W          = 20;  // numerator magnitude
  localparam int STRIP_W        = 11;
  localparam logic [STRIP_W-1:0] STRIP_RST = 11'd1024;

  typedef enum logic [2:0] {
    OP_LINE     = 3'd0,
    OP_GRAD     = 3'd1,
    OP_GRAD3    = 3'd2,
    OP_SPLASH   = 3'd3,
    OP_ROT_UP   = 3'd4,
    OP_ROT_DOWN = 3'd5,
    OP_MIRROR   = 3'd6,
    OP_READ     = 3'd7
  } lsp_op_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_MOD, ST_PIX, ST_CH, ST_DIV, ST_WRITE,
    ST_ROT0, ST_ROT1, ST_MV_RD, ST_MV_WR, ST_ROT_LAST,
    ST_MIR_RD1, ST_MIR_RD2, ST_MIR_WR1, ST_MIR_WR2,
    ST_RD, ST_RD2, ST_DONE
  } lsp_state_t;

  // Channel 0 is red (top byte), 1 green, 2 blue.
  function automatic logic [7:0] chan_get(input logic [23:0] c, input logic [1:0] ch);
    logic [7:0] v;
    unique case (ch)
      2'd0:    v = c[23:16];
      2'd1:    v = c[15:8];
      default: v = c[7:0];
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/lsp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lsp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/lsp_div.sv -----
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsp_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [lsp_pkg::DVD_W-1:0] dividend,
  input  logic [lsp_pkg::IDX_W-1:0] divisor,
  output logic                     done,
  output logic [lsp_pkg::DVD_W-1:0] quotient
);

  localparam int CW = $clog2(lsp_pkg::DVD_W + 1);

  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [lsp_pkg::IDX_W-1:0]     rem_r, rem_nxt;
  logic [lsp_pkg::IDX_W-1:0]     den_r, den_nxt;
  logic [lsp_pkg::DVD_W-1:0]     quo_r, quo_nxt;
  logic [lsp_pkg::IDX_W:0]       shifted;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    shifted  = {rem_r, quo_r[lsp_pkg::DVD_W-1]};
    if (start) begin
      cnt_nxt  = CW'(lsp_pkg::DVD_W);
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      den_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it fits the index width.
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = lsp_pkg::IDX_W'(shifted - {1'b0, den_r});
        quo_nxt = {quo_r[lsp_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = lsp_pkg::IDX_W'(shifted);
        quo_nxt = {quo_r[lsp_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- hdl/led_strip_pattern_engine_core.sv -----
// ----------------------------------------------------------------------------
// LED strip pattern engine
// Pixel store with line, gradient, splash, rotate, mirror and read commands.
// ----------------------------------------------------------------------------
// A read fetches the pixel and presents it. A rotate moves each pixel one
// place, the end one wrapping round. A line pixel passes the pixel, channel
// and write states; a gradient channel also waits on the one shared 20-step
// divider serving all three channels. Mirror swaps pairs. One command is
// in work at a time. After rst_n the store is cleared; no command is taken
// then, configuration writes are. strip_length resets to 1024.
module led_strip_pattern_engine_core #(
  parameter int MAX_PIXELS = lsp_pkg::MAX_PIXELS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[2:0] first[14:3] limit[26:15] center[36:27] radius[47:37]
  // color_a[71:48] color_b[95:72] color_c[119:96]
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,   // read_color[23:0]
  output logic         out_tuser,   // status[0]
  input  logic         cfg_tvalid,
  output logic         cfg_tready,
  input  logic [15:0]  cfg_tdata    // strip_length[10:0]
);

  localparam int AW = $clog2(MAX_PIXELS);
  localparam int IW = lsp_pkg::IDX_W;
  localparam int NW = lsp_pkg::NUM_W;

  lsp_pkg::lsp_state_t state_r, state_nxt;
  lsp_pkg::lsp_op_t    op_r, op_nxt;

  logic [lsp_pkg::STRIP_W-1:0] strip_r;
  logic [AW-1:0]               clr_r, clr_nxt;
  logic [IW-1:0]               first_r, first_nxt, limit_r, limit_nxt;
  logic [9:0]                  center_r, center_nxt;
  logic [10:0]                 radius_r, radius_nxt;
  logic [23:0]                 ca_r, ca_nxt, cb_r, cb_nxt, cc_r, cc_nxt;
  logic [IW-1:0]               k_r, k_nxt, i_r, i_nxt, len_r, len_nxt, len2_r, len2_nxt;
  logic [IW-1:0]               p_r, p_nxt, cnt_r, cnt_nxt;
  logic [23:0]                 c1_r, c1_nxt, c2_r, c2_nxt, c3_r, c3_nxt;
  logic signed [NW-1:0]        num_r [3];
  logic signed [NW-1:0]        num_nxt [3];
  logic [1:0]                  ch_r, ch_nxt;
  logic [23:0]                 pix_r, pix_nxt, tmp_r, tmp_nxt;
  logic signed [IW:0]          mi_r, mi_nxt, mj_r, mj_nxt;
  logic [23:0]                 res_color_r, res_color_nxt;
  logic                        res_rej_r, res_rej_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [23:0]                 out_color_r, out_color_nxt;
  logic                        out_rej_r, out_rej_nxt;

  logic [IW-1:0]        n;
  logic signed [IW:0]   ns, fs, ls, cs, rs, ss, es;
  logic                 rej_cmd, empty_cmd, in_acc, out_free;
  logic signed [NW-1:0] num_sel;
  logic                 num_neg;
  logic [NW-1:0]        num_mag;
  logic [7:0]           c1_ch, q8, ch_val;
  logic signed [8:0]    diff [3];
  logic [IW-1:0]        k_inc;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [23:0]                 ram_wdata, ram_rdata;
  logic                        div_start, div_done;
  logic [lsp_pkg::DVD_W-1:0]   div_q;

  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == lsp_pkg::ST_IDLE);
  assign cfg_tready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_color_r;
  assign out_tuser  = out_rej_r;

  // Strip length in use, clamped to [1, MAX_PIXELS].
  always_comb begin
    if (strip_r == '0) begin
      n = IW'(1);
    end else if (32'(strip_r) > MAX_PIXELS) begin
      n = IW'(MAX_PIXELS);
    end else begin
      n = IW'(strip_r);
    end
  end

  always_comb begin
    ns = $signed({1'b0, n});
    fs = $signed({first_r[IW-1], first_r});
    ls = $signed({limit_r[IW-1], limit_r});
    cs = $signed((IW+1)'(center_r));
    rs = $signed((IW+1)'(radius_r));
    ss = (cs - rs < 0) ? '0 : cs - rs;
    es = (cs + rs > ns) ? ns : cs + rs;
    rej_cmd   = 1'b0;
    empty_cmd = 1'b0;
    unique case (op_r)
      lsp_pkg::OP_LINE, lsp_pkg::OP_GRAD: begin
        rej_cmd   = (fs < -ns);
        empty_cmd = (ls <= fs);
      end
      lsp_pkg::OP_SPLASH: rej_cmd = (center_r == '0) || ({2'b0, center_r} >= n) ||
                                    (radius_r == '0);
      lsp_pkg::OP_MIRROR: rej_cmd = first_r[IW-1] || (ls > ns);
      lsp_pkg::OP_READ:   rej_cmd = first_r[IW-1] || (fs >= ns);
      default:            rej_cmd = 1'b0;
    endcase
  end

  always_comb begin
    num_sel = num_r[ch_r];
    num_neg = num_sel[NW-1];
    num_mag = num_neg ? NW'(-num_sel) : NW'(num_sel);
    c1_ch   = lsp_pkg::chan_get(c1_r, ch_r);
    q8      = div_q[7:0];
    ch_val  = num_neg ? 8'(c1_ch - q8) : 8'(c1_ch + q8);
    for (int c = 0; c < 3; c++) begin
      diff[c] = $signed({1'b0, lsp_pkg::chan_get(c2_r, 2'(c))}) -
                $signed({1'b0, lsp_pkg::chan_get(c1_r, 2'(c))});
    end
    k_inc = (k_r + IW'(1) == n) ? '0 : k_r + IW'(1);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsp_pkg::ST_CLEAR: if (clr_r == AW'(MAX_PIXELS - 1)) state_nxt = lsp_pkg::ST_IDLE;
      lsp_pkg::ST_IDLE:  if (in_acc) state_nxt = lsp_pkg::ST_SETUP;
      lsp_pkg::ST_SETUP: begin
        unique case (op_r)
          lsp_pkg::OP_LINE, lsp_pkg::OP_GRAD: begin
            if (rej_cmd || empty_cmd)  state_nxt = lsp_pkg::ST_DONE;
            else if (first_r[IW-1])    state_nxt = lsp_pkg::ST_PIX;
            else                       state_nxt = lsp_pkg::ST_MOD;
          end
          lsp_pkg::OP_GRAD3:  state_nxt = lsp_pkg::ST_PIX;
          lsp_pkg::OP_SPLASH: state_nxt = rej_cmd ? lsp_pkg::ST_DONE : lsp_pkg::ST_PIX;
          lsp_pkg::OP_ROT_UP, lsp_pkg::OP_ROT_DOWN: state_nxt = lsp_pkg::ST_ROT0;
          lsp_pkg::OP_MIRROR: state_nxt = rej_cmd ? lsp_pkg::ST_DONE : lsp_pkg::ST_MIR_RD1;
          default:            state_nxt = rej_cmd ? lsp_pkg::ST_DONE : lsp_pkg::ST_RD;
        endcase
      end
      lsp_pkg::ST_MOD: if (k_r < n) state_nxt = lsp_pkg::ST_PIX;
      lsp_pkg::ST_PIX: begin
        if (i_r != len_r)        state_nxt = lsp_pkg::ST_CH;
        else if (len2_r == '0)   state_nxt = lsp_pkg::ST_DONE;
      end
      lsp_pkg::ST_CH: begin
        if (num_sel != '0)       state_nxt = lsp_pkg::ST_DIV;
        else if (ch_r == 2'd2)   state_nxt = lsp_pkg::ST_WRITE;
      end
      lsp_pkg::ST_DIV: begin
        if (div_done) state_nxt = (ch_r == 2'd2) ? lsp_pkg::ST_WRITE : lsp_pkg::ST_CH;
      end
      lsp_pkg::ST_WRITE:    state_nxt = lsp_pkg::ST_PIX;
      lsp_pkg::ST_ROT0:     state_nxt = lsp_pkg::ST_ROT1;
      lsp_pkg::ST_ROT1:     state_nxt = lsp_pkg::ST_MV_RD;
      lsp_pkg::ST_MV_RD:    state_nxt = (cnt_r == '0) ? lsp_pkg::ST_ROT_LAST : lsp_pkg::ST_MV_WR;
      lsp_pkg::ST_MV_WR:    state_nxt = lsp_pkg::ST_MV_RD;
      lsp_pkg::ST_ROT_LAST: state_nxt = lsp_pkg::ST_DONE;
      lsp_pkg::ST_MIR_RD1:  state_nxt = (mi_r < mj_r) ? lsp_pkg::ST_MIR_RD2 : lsp_pkg::ST_DONE;
      lsp_pkg::ST_MIR_RD2:  state_nxt = lsp_pkg::ST_MIR_WR1;
      lsp_pkg::ST_MIR_WR1:  state_nxt = lsp_pkg::ST_MIR_WR2;
      lsp_pkg::ST_MIR_WR2:  state_nxt = lsp_pkg::ST_MIR_RD1;
      lsp_pkg::ST_RD:       state_nxt = lsp_pkg::ST_RD2;
      lsp_pkg::ST_RD2:      state_nxt = lsp_pkg::ST_DONE;
      lsp_pkg::ST_DONE:     if (out_free) state_nxt = lsp_pkg::ST_IDLE;
      default:              state_nxt = lsp_pkg::ST_IDLE;
    endcase
  end

  // Store port and divider controls.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(k_r);
    ram_wdata = pix_r;
    ram_raddr = AW'(p_r);
    div_start = 1'b0;
    unique case (state_r)
      lsp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      lsp_pkg::ST_CH:    div_start = (num_sel != '0);
      lsp_pkg::ST_WRITE: ram_we = 1'b1;
      lsp_pkg::ST_ROT0:  ram_raddr = (op_r == lsp_pkg::OP_ROT_UP) ? AW'(n - IW'(1)) : '0;
      lsp_pkg::ST_MV_RD: ram_raddr = (op_r == lsp_pkg::OP_ROT_UP) ? AW'(p_r - IW'(1)) : AW'(p_r);
      lsp_pkg::ST_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = (op_r == lsp_pkg::OP_ROT_UP) ? AW'(p_r) : AW'(p_r - IW'(1));
        ram_wdata = ram_rdata;
      end
      lsp_pkg::ST_ROT_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = (op_r == lsp_pkg::OP_ROT_UP) ? '0 : AW'(n - IW'(1));
        ram_wdata = tmp_r;
      end
      lsp_pkg::ST_MIR_RD1: ram_raddr = AW'(mi_r[IW-1:0]);
      lsp_pkg::ST_MIR_RD2: ram_raddr = AW'(mj_r[IW-1:0]);
      lsp_pkg::ST_MIR_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(mi_r[IW-1:0]);
        ram_wdata = ram_rdata;
      end
      lsp_pkg::ST_MIR_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(mj_r[IW-1:0]);
        ram_wdata = tmp_r;
      end
      lsp_pkg::ST_RD: ram_raddr = AW'(first_r);
      default: ;
    endcase
  end

  // Datapath registers.
  always_comb begin
    op_nxt = op_r;   first_nxt = first_r;   limit_nxt = limit_r;
    center_nxt = center_r;   radius_nxt = radius_r;
    ca_nxt = ca_r;   cb_nxt = cb_r;   cc_nxt = cc_r;
    clr_nxt = clr_r;
    k_nxt = k_r;   i_nxt = i_r;   len_nxt = len_r;   len2_nxt = len2_r;
    p_nxt = p_r;   cnt_nxt = cnt_r;
    c1_nxt = c1_r;   c2_nxt = c2_r;   c3_nxt = c3_r;
    num_nxt = num_r;
    ch_nxt = ch_r;   pix_nxt = pix_r;   tmp_nxt = tmp_r;
    mi_nxt = mi_r;   mj_nxt = mj_r;
    res_color_nxt = res_color_r;   res_rej_nxt = res_rej_r;
    out_valid_nxt = out_valid_r;   out_color_nxt = out_color_r;   out_rej_nxt = out_rej_r;

    if (out_tvalid && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      lsp_pkg::ST_CLEAR: clr_nxt = clr_r + AW'(1);
      lsp_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_nxt     = lsp_pkg::lsp_op_t'(in_tdata[2:0]);
          first_nxt  = in_tdata[14:3];
          limit_nxt  = in_tdata[26:15];
          center_nxt = in_tdata[36:27];
          radius_nxt = in_tdata[47:37];
          ca_nxt     = in_tdata[71:48];
          cb_nxt     = in_tdata[95:72];
          cc_nxt     = in_tdata[119:96];
        end
      end
      lsp_pkg::ST_SETUP: begin
        res_color_nxt = '0;
        res_rej_nxt   = rej_cmd;
        i_nxt         = '0;
        ch_nxt        = '0;
        for (int c = 0; c < 3; c++) num_nxt[c] = '0;
        unique case (op_r)
          lsp_pkg::OP_LINE, lsp_pkg::OP_GRAD: begin
            len_nxt  = IW'(ls - fs);
            len2_nxt = '0;
            k_nxt    = first_r[IW-1] ? IW'(ns + fs) : first_r;
            c1_nxt   = ca_r;
            c2_nxt   = (op_r == lsp_pkg::OP_LINE) ? ca_r : cb_r;
          end
          lsp_pkg::OP_GRAD3: begin
            k_nxt    = '0;
            len_nxt  = n >> 1;
            len2_nxt = n - (n >> 1);
            c1_nxt   = ca_r;
            c2_nxt   = cb_r;
            c3_nxt   = cc_r;
          end
          lsp_pkg::OP_SPLASH: begin
            k_nxt    = IW'(ss);
            len_nxt  = IW'(cs - ss);
            len2_nxt = IW'(es - cs);
            c1_nxt   = '0;
            c2_nxt   = ca_r;
            c3_nxt   = '0;
          end
          lsp_pkg::OP_ROT_UP, lsp_pkg::OP_ROT_DOWN: begin
            p_nxt   = (op_r == lsp_pkg::OP_ROT_UP) ? n - IW'(1) : IW'(1);
            cnt_nxt = n - IW'(1);
          end
          lsp_pkg::OP_MIRROR: begin
            mi_nxt = fs;
            mj_nxt = ls - (IW+1)'(1);
          end
          default: ;
        endcase
      end
      // Nonnegative start index is reduced modulo the strip length.
      lsp_pkg::ST_MOD: if (k_r >= n) k_nxt = k_r - n;
      lsp_pkg::ST_PIX: begin
        // The second half of a two-part gradient continues at the next index.
        if (i_r == len_r && len2_r != '0) begin
          len_nxt  = len2_r;
          len2_nxt = '0;
          i_nxt    = '0;
          c1_nxt   = c2_r;
          c2_nxt   = c3_r;
          for (int c = 0; c < 3; c++) num_nxt[c] = '0;
        end
        ch_nxt = '0;
      end
      lsp_pkg::ST_CH: begin
        if (num_sel == '0) begin
          unique case (ch_r)
            2'd0:    pix_nxt[23:16] = c1_ch;
            2'd1:    pix_nxt[15:8]  = c1_ch;
            default: pix_nxt[7:0]   = c1_ch;
          endcase
          ch_nxt = ch_r + 2'd1;
        end
      end
      lsp_pkg::ST_DIV: begin
        if (div_done) begin
          unique case (ch_r)
            2'd0:    pix_nxt[23:16] = ch_val;
            2'd1:    pix_nxt[15:8]  = ch_val;
            default: pix_nxt[7:0]   = ch_val;
          endcase
          ch_nxt = ch_r + 2'd1;
        end
      end
      lsp_pkg::ST_WRITE: begin
        for (int c = 0; c < 3; c++) num_nxt[c] = num_r[c] + NW'(diff[c]);
        i_nxt = i_r + IW'(1);
        k_nxt = k_inc;
      end
      lsp_pkg::ST_ROT1: tmp_nxt = ram_rdata;
      lsp_pkg::ST_MV_WR: begin
        p_nxt   = (op_r == lsp_pkg::OP_ROT_UP) ? p_r - IW'(1) : p_r + IW'(1);
        cnt_nxt = cnt_r - IW'(1);
      end
      lsp_pkg::ST_MIR_RD2: tmp_nxt = ram_rdata;
      lsp_pkg::ST_MIR_WR2: begin
        mi_nxt = mi_r + (IW+1)'(1);
        mj_nxt = mj_r - (IW+1)'(1);
      end
      lsp_pkg::ST_RD2: res_color_nxt = ram_rdata;
      lsp_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = res_color_r;
          out_rej_nxt   = res_rej_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsp_pkg::ST_CLEAR;
      clr_r       <= '0;
      strip_r     <= lsp_pkg::STRIP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_tvalid && cfg_tready) strip_r <= cfg_tdata[lsp_pkg::STRIP_W-1:0];
    end
    op_r <= op_nxt;   first_r <= first_nxt;   limit_r <= limit_nxt;
    center_r <= center_nxt;   radius_r <= radius_nxt;
    ca_r <= ca_nxt;   cb_r <= cb_nxt;   cc_r <= cc_nxt;
    k_r <= k_nxt;   i_r <= i_nxt;   len_r <= len_nxt;   len2_r <= len2_nxt;
    p_r <= p_nxt;   cnt_r <= cnt_nxt;
    c1_r <= c1_nxt;   c2_r <= c2_nxt;   c3_r <= c3_nxt;
    num_r <= num_nxt;
    ch_r <= ch_nxt;   pix_r <= pix_nxt;   tmp_r <= tmp_nxt;
    mi_r <= mi_nxt;   mj_r <= mj_nxt;
    res_color_r <= res_color_nxt;   res_rej_r <= res_rej_nxt;
    out_color_r <= out_color_nxt;   out_rej_r <= out_rej_nxt;
  end

  lsp_ram #(
    .WIDTH (24),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lsp_pkg::DVD_W'(num_mag)),
    .divisor  (len_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Command writes never land beyond the strip in use.
  a_write_in_strip: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != lsp_pkg::ST_CLEAR) |-> (32'(ram_waddr) < 32'(n)))
    else $error("store write outside strip");

  // A divider result only arrives while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == lsp_pkg::ST_DIV))
    else $error("divider result outside divide wait");

  // A finished command presents its result on the next cycle.
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lsp_pkg::ST_DONE && out_free) |=> out_tvalid)
    else $error("finished command lost its result");

endmodule
